[src/kms_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kms_pkg
// Shared types, constants and the key table for the keyboard matrix scanner.
// ----------------------------------------------------------------------------
package kms_pkg;

    // Number of scan phases. Phase zero drives, phase one reads, the rest idle.
    localparam int unsigned SCAN_PHASES = 2;
    localparam int unsigned PHASE_W     = 4;
    localparam int unsigned LINE_W      = 7;
    localparam int unsigned SENSE_W     = 6;
    localparam int unsigned CODE_W      = 13;
    localparam int unsigned CHAR_W      = 7;
    localparam int unsigned KEY_COUNT   = 35;

    // Phase codes.
    localparam logic [PHASE_W-1:0] PHASE_DRIVE = PHASE_W'(0);
    localparam logic [PHASE_W-1:0] PHASE_READ  = PHASE_W'(1);
    localparam logic [PHASE_W-1:0] PHASE_LAST  = PHASE_W'(SCAN_PHASES - 1);

    // Drive line after reset, and the last line before the wrap.
    localparam logic [LINE_W-1:0] LINE_FIRST = 7'h01;
    localparam logic [LINE_W-1:0] LINE_LAST  = 7'h40;

    // Character reported for the ON key.
    localparam logic [CHAR_W-1:0] CHAR_ON   = 7'h6F;
    localparam logic [CHAR_W-1:0] CHAR_NONE = 7'h00;

    // Word carried by the input channel: one scan tick.
    typedef struct packed {
        logic [7:0] sense_byte;
        logic       kept_latch_bit;
    } tick_word_t;

    // Word carried by the output channel: one scan result.
    typedef struct packed {
        logic              latch_write;
        logic [7:0]        latch_byte;
        logic              key_found;
        logic [CHAR_W-1:0] key_char;
    } result_word_t;

    // Outcome of a key table lookup.
    typedef struct packed {
        logic              hit;
        logic [CHAR_W-1:0] key_char;
    } key_hit_t;

    // Key table: code is sense value in bits 12..8, drive line in bits 6..0.
    function automatic logic [CODE_W-1:0] key_code(input int unsigned idx);
        logic [CODE_W-1:0] c;
        case (idx)
            0:  c = 13'h1002;  1:  c = 13'h1004;  2:  c = 13'h1008;
            3:  c = 13'h1040;  4:  c = 13'h1010;  5:  c = 13'h1020;
            6:  c = 13'h0802;  7:  c = 13'h0804;  8:  c = 13'h0808;
            9:  c = 13'h0840;  10: c = 13'h0810;  11: c = 13'h0820;
            12: c = 13'h0402;  13: c = 13'h0404;  14: c = 13'h0408;
            15: c = 13'h0440;  16: c = 13'h0410;  17: c = 13'h0420;
            18: c = 13'h0202;  19: c = 13'h0204;  20: c = 13'h0208;
            21: c = 13'h0240;  22: c = 13'h0210;  23: c = 13'h0220;
            24: c = 13'h0108;  25: c = 13'h0140;  26: c = 13'h0101;
            27: c = 13'h0120;  28: c = 13'h0102;  29: c = 13'h0104;
            30: c = 13'h0801;  31: c = 13'h1001;  32: c = 13'h0201;
            33: c = 13'h0401;  34: c = 13'h0110;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] key_ascii(input int unsigned idx);
        logic [CHAR_W-1:0] a;
        case (idx)
            0:  a = 7'h41;  1:  a = 7'h42;  2:  a = 7'h43;  3:  a = 7'h44;
            4:  a = 7'h45;  5:  a = 7'h46;  6:  a = 7'h47;  7:  a = 7'h48;
            8:  a = 7'h49;  9:  a = 7'h4A;  10: a = 7'h4B;  11: a = 7'h4C;
            12: a = 7'h4D;  13: a = 7'h4E;  14: a = 7'h4F;  15: a = 7'h50;
            16: a = 7'h51;  17: a = 7'h52;  18: a = 7'h53;  19: a = 7'h54;
            20: a = 7'h55;  21: a = 7'h56;  22: a = 7'h57;  23: a = 7'h58;
            24: a = 7'h59;  25: a = 7'h5A;  26: a = 7'h6D;  27: a = 7'h78;
            28: a = 7'h73;  29: a = 7'h2D;  30: a = 7'h6C;  31: a = 7'h72;
            32: a = 7'h75;  33: a = 7'h64;  34: a = 7'h20;
            default: a = CHAR_NONE;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

[src/kms_key_decode.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kms_key_decode
// Matches a 13-bit matrix code against the fixed key table in parallel.
// ----------------------------------------------------------------------------
module kms_key_decode (
    input  wire logic [kms_pkg::CODE_W-1:0] code,
    output kms_pkg::key_hit_t               result
);
    import kms_pkg::*;

    logic [KEY_COUNT-1:0] match;

    // One comparator per table entry.
    always_comb
    begin
        for (int unsigned i = 0; i < KEY_COUNT; i++)
        begin
            match[i] = (code == key_code(i));
        end
    end

    // Codes in the table are distinct, so at most one entry matches.
    always_comb
    begin
        result.hit      = |match;
        result.key_char = CHAR_NONE;
        for (int unsigned i = 0; i < KEY_COUNT; i++)
        begin
            if (match[i])
            begin
                result.key_char = result.key_char | key_ascii(i);
            end
        end
    end

endmodule
`default_nettype wire

[src/keyboard_matrix_scanner.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// keyboard_matrix_scanner
// Steps through drive and read phases of a key matrix and reports keys.
// ----------------------------------------------------------------------------
//  Channel  Signals                          Direction  Word type
//  tick     tick_valid / tick_stall / tick   in         tick_word_t
//  result   result_valid / result_stall /    out        result_word_t
//           result
//
//  One scan tick is taken every cycle while tick_stall is low; its result
//  word appears in the next cycle from the result register, the only stage.
//  A tick is still taken while a result waits, as long as that result is
//  taken in the same cycle; otherwise tick_stall follows result_stall.
//  Reset puts the scanner in the drive phase with drive line 0x01 and no
//  line remembered, and empties the result register.
// ----------------------------------------------------------------------------
module keyboard_matrix_scanner (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  tick_valid,
    output logic                       tick_stall,
    input  wire kms_pkg::tick_word_t   tick,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output kms_pkg::result_word_t      result
);
    import kms_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [LINE_W-1:0]  line_reg, line_next;
    logic [LINE_W-1:0]  column_reg, column_next;
    logic               valid_reg, valid_next;
    result_word_t       word_reg, word_next;

    logic               take;
    logic [SENSE_W-1:0] sense;
    logic [CODE_W-1:0]  code;
    key_hit_t           hit;

    // A tick is taken when the result register is empty or being emptied.
    assign tick_stall = valid_reg & result_stall;
    assign take       = tick_valid & ~tick_stall;

    // Code for the table: sense lines above the remembered drive line.
    assign sense = tick.sense_byte[7:2];
    assign code  = {sense[4:0], 1'b0, column_reg};

    kms_key_decode u_decode (
        .code   (code),
        .result (hit)
    );

    // Phase step and result word for the tick now offered.
    always_comb
    begin
        phase_next  = phase_reg;
        line_next   = line_reg;
        column_next = column_reg;
        word_next   = '0;

        if (phase_reg == PHASE_DRIVE)
        begin
            word_next.latch_write = 1'b1;
            word_next.latch_byte  = {tick.kept_latch_bit, line_reg};
            column_next           = line_reg;
            line_next = (line_reg == LINE_LAST) ? LINE_FIRST
                                                : {line_reg[LINE_W-2:0], 1'b0};
        end
        else if (phase_reg == PHASE_READ)
        begin
            if (sense[5])
            begin
                word_next.key_found = 1'b1;
                word_next.key_char  = CHAR_ON;
            end
            else if (sense != '0)
            begin
                word_next.key_found = hit.hit;
                word_next.key_char  = hit.key_char;
            end
        end

        phase_next = (phase_reg == PHASE_LAST) ? PHASE_DRIVE
                                               : phase_reg + PHASE_W'(1);
    end

    // Result register occupancy.
    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (~result_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // Scan state and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PHASE_DRIVE;
            line_reg   <= LINE_FIRST;
            column_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (take)
            begin
                phase_reg  <= phase_next;
                line_reg   <= line_next;
                column_reg <= column_next;
            end
        end
    end

    // Result word payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= word_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = word_reg;

endmodule
`default_nettype wire

[src/kms_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kms_checker
// Port-level checks on the keyboard matrix scanner, bound to the top level.
// ----------------------------------------------------------------------------
module kms_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  tick_stall,
    input wire logic                  result_valid,
    input wire logic                  result_stall,
    input wire kms_pkg::result_word_t result
);
    import kms_pkg::*;

    // A drive word never reports a key and drives exactly one line.
    a_drive_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.latch_write
            |-> !result.key_found && $onehot(result.latch_byte[6:0]))
        else $error("drive word reports a key or drives a wrong line");

    // A word that does not write the latch carries a zero latch byte.
    a_quiet_latch: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.latch_write |-> result.latch_byte == 8'h00)
        else $error("latch byte set on a word without a latch write");

    // No character without a recognised key.
    a_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.key_found |-> result.key_char == CHAR_NONE)
        else $error("character reported without a key");

    // An empty result register never holds back the tick channel.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !tick_stall)
        else $error("tick stalled while no result is waiting");

    // A stalled result word holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result word changed");

endmodule

bind keyboard_matrix_scanner kms_checker u_kms_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_stall   (tick_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
`default_nettype wire

[dv/tb_keyboard_matrix_scanner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyboard_matrix_scanner
// Self-checking bench for the keyboard matrix scanner. A mirror of the scan
// sequence predicts every result word from the tick words that the block
// takes, and compares them in order. A directed opening covers the corner
// cases. Mostly well-formed key presses with random idling on both channels
// follow.
// ----------------------------------------------------------------------------
module tb_keyboard_matrix_scanner;
    import kms_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    // Follows the scan sequence and holds the result words still to come.
    class scan_mirror;
        logic [PHASE_W-1:0] phase;
        logic [LINE_W-1:0]  line;
        logic [LINE_W-1:0]  column;
        result_word_t       pending_results[$];
        int                 mismatches;

        function new();
            phase      = PHASE_DRIVE;
            line       = LINE_FIRST;
            column     = '0;
            mismatches = 0;
        endfunction

        // Character for a matrix code, or zero when the code is not a key.
        function logic [7:0] key_from_code(input logic [CODE_W-1:0] code);
            logic [7:0] ch;
            case (code)
                13'h1002: ch = "A";  13'h1004: ch = "B";  13'h1008: ch = "C";
                13'h1040: ch = "D";  13'h1010: ch = "E";  13'h1020: ch = "F";
                13'h0802: ch = "G";  13'h0804: ch = "H";  13'h0808: ch = "I";
                13'h0840: ch = "J";  13'h0810: ch = "K";  13'h0820: ch = "L";
                13'h0402: ch = "M";  13'h0404: ch = "N";  13'h0408: ch = "O";
                13'h0440: ch = "P";  13'h0410: ch = "Q";  13'h0420: ch = "R";
                13'h0202: ch = "S";  13'h0204: ch = "T";  13'h0208: ch = "U";
                13'h0240: ch = "V";  13'h0210: ch = "W";  13'h0220: ch = "X";
                13'h0108: ch = "Y";  13'h0140: ch = "Z";  13'h0101: ch = "m";
                13'h0120: ch = "x";  13'h0102: ch = "s";  13'h0104: ch = "-";
                13'h0801: ch = "l";  13'h1001: ch = "r";  13'h0201: ch = "u";
                13'h0401: ch = "d";  13'h0110: ch = " ";
                default:  ch = 8'h00;
            endcase
            return ch;
        endfunction

        // Works out the result word of one accepted tick and steps the phase.
        function void take_tick(input tick_word_t w);
            result_word_t r;
            logic [5:0]   s;
            logic [7:0]   ch;
            r = '0;
            if (phase == PHASE_DRIVE)
            begin
                r.latch_write = 1'b1;
                r.latch_byte  = {w.kept_latch_bit, line};
                column        = line;
                line          = (line == LINE_LAST) ? LINE_FIRST : {line[5:0], 1'b0};
            end
            else if (phase == PHASE_READ)
            begin
                s = w.sense_byte[7:2];
                if (s[5])
                begin
                    // The ON key wins over any other line.
                    r.key_found = 1'b1;
                    r.key_char  = CHAR_ON;
                end
                else if (s != '0)
                begin
                    ch          = key_from_code({s[4:0], 1'b0, column});
                    r.key_found = (ch != 8'h00);
                    r.key_char  = ch[6:0];
                end
            end
            phase = (phase == PHASE_LAST) ? PHASE_DRIVE : phase + 1'b1;
            pending_results.push_back(r);
        endfunction

        function void report(input string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at %0t: %s", $realtime, msg);
        endfunction

        // Compares one accepted result word with the oldest prediction.
        function void compare_result(input result_word_t got);
            result_word_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("word lw=%0d lb=%02h kf=%0d ch=%02h with no tick behind it",
                                 got.latch_write, got.latch_byte, got.key_found,
                                 got.key_char));
                return;
            end
            want = pending_results.pop_front();
            if (got.latch_write !== want.latch_write || got.latch_byte !== want.latch_byte ||
                got.key_found !== want.key_found || got.key_char !== want.key_char)
                report($sformatf("expected lw=%0d lb=%02h kf=%0d ch=%02h, got lw=%0d lb=%02h kf=%0d ch=%02h",
                                 want.latch_write, want.latch_byte, want.key_found,
                                 want.key_char, got.latch_write, got.latch_byte,
                                 got.key_found, got.key_char));
        endfunction
    endclass

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         tick_valid   = 1'b0;
    logic         tick_stall;
    tick_word_t   tick         = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_word_t result;

    scan_mirror   mirror;
    bit           idling      = 1'b1;
    int           stall_left  = 0;
    int           quiet_cycles = 0;

    keyboard_matrix_scanner dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #2 clk = ~clk;

    // Result side: take words and stall in random bursts.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            mirror.compare_result(result);
        if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (idling && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 15);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // Watchdog: too long without any word moving on either channel.
    always @(posedge clk)
    begin
        if ((tick_valid && !tick_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("tb_keyboard_matrix_scanner: errors");
            $finish;
        end
    end

    // Random tick. On read ticks most words press a single key on the
    // remembered line, some press ON, the rest are raw noise.
    function automatic tick_word_t random_tick();
        tick_word_t w;
        int         pick;
        w.kept_latch_bit = 1'($urandom_range(0, 1));
        w.sense_byte     = 8'($urandom_range(0, 255));
        if (mirror.phase == PHASE_READ)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                w.sense_byte = {1'b0, 5'(1 << $urandom_range(0, 4)), w.sense_byte[1:0]};
            else if (pick < 8)
                w.sense_byte[7] = 1'b1;
        end
        return w;
    endfunction

    // Offers one tick word and holds it until the block takes it.
    task automatic put_tick(input tick_word_t w);
        tick       <= w;
        tick_valid <= 1'b1;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        mirror.take_tick(w);
    endtask

    task automatic send_random(input int count);
        int k;
        for (k = 0; k < count; k++)
        begin
            if (idling && $urandom_range(0, 7) == 0)
            begin
                tick_valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            put_tick(random_tick());
        end
    endtask

    initial
    begin
        // Drive and read ticks alternate; the comment gives the read outcome.
        tick_word_t plan [20];
        int         k;
        plan = '{
            {8'hFF, 1'b1}, {8'h00, 1'b0},   // latch 0x81, no lines active
            {8'h00, 1'b0}, {8'hFF, 1'b1},   // every line active, ON wins
            {8'h5A, 1'b1}, {8'h80, 1'b0},   // ON key alone
            {8'hFF, 1'b0}, {8'h03, 1'b1},   // only the unused low bits set
            {8'h00, 1'b1}, {8'h40, 1'b0},   // key E
            {8'hA5, 1'b0}, {8'h0C, 1'b1},   // two lines, not a key
            {8'h00, 1'b1}, {8'h04, 1'b0},   // key Z on the last line
            {8'h00, 1'b0}, {8'h20, 1'b1},   // line wraps to 0x01, key l
            {8'hFF, 1'b1}, {8'h7F, 1'b0},   // five lines, not a key
            {8'h00, 1'b0}, {8'h08, 1'b1}    // key T
        };
        mirror = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < 20; k++)
            put_tick(plan[k]);

        send_random(700);

        // Hold off until the block has returned every word.
        tick_valid <= 1'b0;
        while (mirror.pending_results.size() != 0)
            @(posedge clk);

        send_random(700);

        // Closing stretch at full rate on both channels.
        idling = 1'b0;
        send_random(50);

        tick_valid <= 1'b0;
        while (mirror.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (mirror.mismatches == 0)
            $display("tb_keyboard_matrix_scanner: clean");
        else
            $display("tb_keyboard_matrix_scanner: errors");
        $finish;
    end

endmodule
